// File: rtl/tach_pkg.sv
// ---------------------------------------------------------------------------
// tach_pkg: shared constants for the multichannel tachometer
// Field widths, register indexes and the rpm numerator.
// ---------------------------------------------------------------------------
`default_nettype none

package tach_pkg;

  // field widths
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned TPR_W      = 8;
  localparam int unsigned PROD_W     = TIME_W + TPR_W;
  localparam int unsigned CH_W       = 2;
  localparam int unsigned MAX_CHANNELS = 4;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_ENABLE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TPR_CH0        = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TPR_CH1        = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TPR_CH2        = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_TPR_CH3        = 3'd4;

  // input kinds
  localparam logic KIND_EDGE    = 1'b0;
  localparam logic KIND_REFRESH = 1'b1;

  // ms per minute, the dividend of every speed evaluation
  localparam logic [SPEED_W-1:0] RPM_NUMERATOR = 16'd60000;

  // stream payload widths
  localparam int unsigned S_DATA_W = 40;
  localparam int unsigned M_DATA_W = 64;

endpackage

`default_nettype wire

// File: rtl/tach_mul.sv
// ---------------------------------------------------------------------------
// tach_mul: bit-serial multiplier
// Shift-add product of a 32-bit elapsed time and an 8-bit pulse count,
// one multiplier bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module tach_mul (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [tach_pkg::TIME_W-1:0] mcand_in,
  input  wire logic [tach_pkg::TPR_W-1:0]  mplr_in,
  output logic                             done,
  output logic [tach_pkg::PROD_W-1:0]      product
);
  import tach_pkg::*;

  localparam int unsigned CNT_W = $clog2(TPR_W);

  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] mcand;
  logic [TPR_W-1:0]  mplr;
  logic [CNT_W-1:0]  cnt;
  logic              run;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(TPR_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= '0;
      mcand <= PROD_W'(mcand_in);
      mplr  <= mplr_in;
    end else if (run) begin
      if (mplr[0]) begin
        acc <= acc + mcand;
      end
      mcand <= {mcand[PROD_W-2:0], 1'b0};
      mplr  <= {1'b0, mplr[TPR_W-1:1]};
    end
  end

  assign product = acc;

endmodule

`default_nettype wire

// File: rtl/tach_div.sv
// ---------------------------------------------------------------------------
// tach_div: bit-serial restoring divider
// Divides the fixed rpm numerator by a 40-bit denominator, one quotient
// bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module tach_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [tach_pkg::PROD_W-1:0]  den_in,
  output logic                              done,
  output logic [tach_pkg::SPEED_W-1:0]      quotient
);
  import tach_pkg::*;

  localparam int unsigned CNT_W = $clog2(SPEED_W);

  logic [SPEED_W-1:0] num;
  logic [SPEED_W-1:0] rem;
  logic [PROD_W-1:0]  den;
  logic [CNT_W-1:0]   cnt;
  logic               run;
  logic [SPEED_W:0]   rem_shift;
  logic [SPEED_W:0]   rem_diff;
  logic               fits;

  // trial subtract of the shifted partial remainder
  always_comb begin
    rem_shift = {rem, num[SPEED_W-1]};
    fits      = PROD_W'(rem_shift) >= den;
    rem_diff  = rem_shift - den[SPEED_W:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SPEED_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend bits leave at the top, quotient bits enter below
  always_ff @(posedge clk) begin
    if (start) begin
      num <= RPM_NUMERATOR;
      rem <= '0;
      den <= den_in;
    end else if (run) begin
      rem <= fits ? rem_diff[SPEED_W-1:0] : rem_shift[SPEED_W-1:0];
      num <= {num[SPEED_W-2:0], fits};
    end
  end

  assign quotient = num;

endmodule

`default_nettype wire

// File: rtl/multichannel_tachometer_rpm.sv
// ---------------------------------------------------------------------------
// multichannel_tachometer_rpm: period-measurement tachometer, up to 4 channels
// Edge and refresh transactions update per-channel speeds in rpm.
// ---------------------------------------------------------------------------
// Each input transaction is a sensor edge on one channel or a refresh of all
// channels, stamped with a 32-bit millisecond time. A speed evaluation runs
// a bit-serial multiply (pulses per revolution times elapsed time) followed
// by a bit-serial restoring divide of 60000, after a load step; a refresh
// adds a channel step after each channel. An edge that needs no new speed
// skips the multiply and divide; a refresh walks the channels in turn
// through the one shared multiplier and divider. A result that waits on the
// output holds the next one back.
// One transaction is worked on at a time; the result register lets the next
// transaction be accepted while a result still waits on the output.
// Each result carries all four speeds; disabled channels read zero.
`default_nettype none

module multichannel_tachometer_rpm #(
  parameter int unsigned NB_CHANNELS = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [tach_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [tach_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [tach_pkg::S_DATA_W-1:0]    s_tdata,  // channel[1:0], now_ms[33:2]
  input  wire logic                             s_tuser,  // kind
  // result stream
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [tach_pkg::M_DATA_W-1:0]         m_tdata   // speed_0..speed_3, 16 bits each
);
  import tach_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_NEXT = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // configuration registers
  logic [MAX_CHANNELS-1:0] ch_enable;
  logic [TPR_W-1:0]        tpr [MAX_CHANNELS];

  // channel state
  logic [TIME_W-1:0]  last_time [NB_CHANNELS];
  logic [TIME_W-1:0]  interval  [NB_CHANNELS];
  logic [SPEED_W-1:0] speed     [NB_CHANNELS];

  // current transaction
  logic              kind;
  logic [CH_W-1:0]   cur;
  logic [TIME_W-1:0] now_ms;

  logic [TIME_W-1:0] sel_last;
  logic [TIME_W-1:0] sel_interval;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] limit;
  logic [TPR_W-1:0]  tpr_eff;
  logic              cur_on;
  logic              eval;
  logic              edge_store;
  logic              last_ch;

  logic               mul_start;
  logic               mul_done;
  logic [PROD_W-1:0]  product;
  logic               div_done;
  logic [SPEED_W-1:0] quotient;
  logic               out_load;
  logic [SPEED_W-1:0] out_speed [MAX_CHANNELS];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ch_enable <= '0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        tpr[c] <= TPR_W'(1);
      end
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CHANNEL_ENABLE: ch_enable <= cfg_wdata[MAX_CHANNELS-1:0];
        REG_TPR_CH0:        tpr[0]    <= cfg_wdata[TPR_W-1:0];
        REG_TPR_CH1:        tpr[1]    <= cfg_wdata[TPR_W-1:0];
        REG_TPR_CH2:        tpr[2]    <= cfg_wdata[TPR_W-1:0];
        REG_TPR_CH3:        tpr[3]    <= cfg_wdata[TPR_W-1:0];
        default: ;
      endcase
    end
  end

  // read the current channel
  always_comb begin
    sel_last     = '0;
    sel_interval = '0;
    for (int c = 0; c < NB_CHANNELS; c++) begin
      if (cur == CH_W'(c)) begin
        sel_last     = last_time[c];
        sel_interval = interval[c];
      end
    end
    cur_on  = (32'(cur) < NB_CHANNELS) && ch_enable[cur];
    elapsed = now_ms - sel_last;
    limit   = sel_last + sel_interval;
    tpr_eff = (tpr[cur] == '0) ? TPR_W'(1) : tpr[cur];
    last_ch = (cur == CH_W'(NB_CHANNELS - 1));
  end

  // decide whether this channel gets a new speed
  always_comb begin
    if (kind == KIND_EDGE) begin
      eval = cur_on && (elapsed != '0);
    end else begin
      eval = cur_on && (now_ms > limit) && (elapsed != '0);
    end
    edge_store = (state == ST_LOAD) && (kind == KIND_EDGE) && cur_on;
    mul_start  = (state == ST_LOAD) && eval;
    out_load   = (state == ST_DONE) && (!m_tvalid || m_tready);
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_LOAD;
      ST_LOAD: begin
        if (eval) begin
          state_next = ST_MUL;
        end else if (kind == KIND_EDGE) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_NEXT;
        end
      end
      ST_MUL:  if (mul_done) state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_next = (kind == KIND_EDGE) ? ST_DONE : ST_NEXT;
        end
      end
      ST_NEXT: state_next = last_ch ? ST_DONE : ST_LOAD;
      ST_DONE: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  // capture the transaction and step the channel index
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      kind   <= s_tuser;
      now_ms <= s_tdata[CH_W +: TIME_W];
      cur    <= (s_tuser == KIND_EDGE) ? s_tdata[CH_W-1:0] : '0;
    end else if (state == ST_NEXT && !last_ch) begin
      cur <= cur + 1'b1;
    end
  end

  // channel state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NB_CHANNELS; c++) begin
        last_time[c] <= '0;
        interval[c]  <= '0;
        speed[c]     <= '0;
      end
    end else begin
      for (int c = 0; c < NB_CHANNELS; c++) begin
        if (edge_store && cur == CH_W'(c)) begin
          last_time[c] <= now_ms;
          interval[c]  <= elapsed;
        end
        if (state == ST_DIV && div_done && cur == CH_W'(c)) begin
          speed[c] <= quotient;
        end
      end
    end
  end

  // shared serial arithmetic
  tach_mul u_mul (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_start),
    .mcand_in (elapsed),
    .mplr_in  (tpr_eff),
    .done     (mul_done),
    .product  (product)
  );

  tach_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_done),
    .den_in   (product),
    .done     (div_done),
    .quotient (quotient)
  );

  // speeds as seen on the output, zero when disabled
  always_comb begin
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      out_speed[c] = '0;
    end
    for (int c = 0; c < NB_CHANNELS; c++) begin
      if (ch_enable[c]) begin
        out_speed[c] = speed[c];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {out_speed[3], out_speed[2], out_speed[1], out_speed[0]};
    end
  end

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: multichannel_tachometer_rpm
// Drives edge and refresh transactions with random gaps on both streams and
// checks every result word against a local model of the tachometer, or
// against given speeds for typed directed cases. A short table of directed
// cases runs first. Random phases follow, each under its own register setting.
// ---------------------------------------------------------------------------
module testbench;
  import tach_pkg::*;

  localparam int unsigned CHANNELS        = 4;
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned ITEMS_PER_PHASE = 185;
  localparam int unsigned MAX_WAIT        = 18;
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned SETTLE_CYCLES   = 150;

  typedef logic [CHANNELS-1:0][SPEED_W-1:0] speed_set_t;

  typedef struct {
    bit                          set_regs;
    logic [CFG_DATA_W-1:0]       enable_byte;
    logic [CHANNELS-1:0][TPR_W-1:0] ppr;
    logic                        kind;
    logic [CH_W-1:0]             ch;
    logic [TIME_W-1:0]           now_ms;
    bit                          typed;
    speed_set_t                  typed_speeds;
  } drill_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;  // channel[1:0], now_ms[33:2]
  logic s_tuser = 1'b0;               // kind
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;       // speed_0..speed_3, 16 bits each

  // tachometer mirror: registers and per-channel state
  logic [CHANNELS-1:0] mirror_enable = '0;
  logic [TPR_W-1:0]    mirror_pulses [CHANNELS] = '{default: 8'd1};
  logic [TIME_W-1:0]   mirror_last_ms [CHANNELS] = '{default: '0};
  logic [TIME_W-1:0]   mirror_interval [CHANNELS] = '{default: '0};
  logic [SPEED_W-1:0]  mirror_rpm [CHANNELS] = '{default: '0};

  speed_set_t  expected_speeds [$];
  drill_row_t  drill [$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idle = 1'b0;
  logic [TIME_W-1:0] wall_ms = '0;

  multichannel_tachometer_rpm #(
    .NB_CHANNELS(CHANNELS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // rpm from pulses per revolution and elapsed ms, zero pulses count as one
  function automatic logic [SPEED_W-1:0] rpm_for(int c, logic [TIME_W-1:0] elapsed);
    logic [TPR_W-1:0]  ppr;
    logic [PROD_W-1:0] divisor;
    logic [PROD_W-1:0] quotient;
    ppr = (mirror_pulses[c] == '0) ? 8'd1 : mirror_pulses[c];
    divisor = {{TIME_W{1'b0}}, ppr} * {{TPR_W{1'b0}}, elapsed};
    quotient = {{(PROD_W-SPEED_W){1'b0}}, RPM_NUMERATOR} / divisor;
    return quotient[SPEED_W-1:0];
  endfunction

  // advance the mirror by one transaction and return the speeds it reports
  function automatic speed_set_t advance_tach(logic kind, logic [CH_W-1:0] ch,
                                              logic [TIME_W-1:0] now_ms);
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] horizon;
    speed_set_t speeds;
    if (kind == KIND_EDGE) begin
      if (mirror_enable[ch]) begin
        elapsed = now_ms - mirror_last_ms[ch];
        if (elapsed != '0) mirror_rpm[ch] = rpm_for(ch, elapsed);
        mirror_interval[ch] = elapsed;
        mirror_last_ms[ch] = now_ms;
      end
    end else begin
      // only channels past their last interval decay
      for (int c = 0; c < CHANNELS; c++) begin
        if (mirror_enable[c]) begin
          horizon = mirror_last_ms[c] + mirror_interval[c];
          elapsed = now_ms - mirror_last_ms[c];
          if (now_ms > horizon && elapsed != '0) mirror_rpm[c] = rpm_for(c, elapsed);
        end
      end
    end
    for (int c = 0; c < CHANNELS; c++) speeds[c] = mirror_enable[c] ? mirror_rpm[c] : '0;
    return speeds;
  endfunction

  // directed table rows
  function automatic drill_row_t edge_row(logic [CH_W-1:0] ch, logic [TIME_W-1:0] now_ms);
    drill_row_t r;
    r = '{default: '0};
    r.kind = KIND_EDGE;
    r.ch = ch;
    r.now_ms = now_ms;
    return r;
  endfunction

  function automatic drill_row_t refresh_row(logic [TIME_W-1:0] now_ms);
    drill_row_t r;
    r = '{default: '0};
    r.kind = KIND_REFRESH;
    r.now_ms = now_ms;
    return r;
  endfunction

  function automatic drill_row_t regs_row(logic [CFG_DATA_W-1:0] enable_byte,
                                          logic [CHANNELS-1:0][TPR_W-1:0] ppr);
    drill_row_t r;
    r = '{default: '0};
    r.set_regs = 1'b1;
    r.enable_byte = enable_byte;
    r.ppr = ppr;
    return r;
  endfunction

  function automatic drill_row_t known(drill_row_t r, speed_set_t speeds);
    drill_row_t k;
    k = r;
    k.typed = 1'b1;
    k.typed_speeds = speeds;
    return k;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // write all five registers back to back, block must be idle
  task automatic apply_regs(input logic [CFG_DATA_W-1:0] enable_byte,
                            input logic [CHANNELS-1:0][TPR_W-1:0] ppr);
    logic [CFG_ADDR_W-1:0] index [5];
    logic [CFG_DATA_W-1:0] value [5];
    index = '{REG_CHANNEL_ENABLE, REG_TPR_CH0, REG_TPR_CH1, REG_TPR_CH2, REG_TPR_CH3};
    value = '{enable_byte, ppr[0], ppr[1], ppr[2], ppr[3]};
    for (int r = 0; r < 5; r++) begin
      cfg_we <= 1'b1;
      cfg_addr <= index[r];
      cfg_wdata <= value[r];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    mirror_enable = enable_byte[CHANNELS-1:0];
    for (int c = 0; c < CHANNELS; c++) mirror_pulses[c] = ppr[c];
  endtask

  // one input transaction; valid stays high when the next one follows at once
  task automatic send_item(input logic kind, input logic [CH_W-1:0] ch,
                           input logic [TIME_W-1:0] now_ms,
                           input bit typed, input speed_set_t typed_speeds);
    int unsigned gap;
    speed_set_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {{(S_DATA_W-TIME_W-CH_W){1'b0}}, now_ms, ch};
    do @(posedge clk); while (!s_tready);
    predicted = advance_tach(kind, ch, now_ms);
    expected_speeds.push_back(typed ? typed_speeds : predicted);
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_speeds.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls, field by field check
  initial begin : result_sink
    int unsigned stall;
    speed_set_t want;
    speed_set_t got;
    wait (!rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = m_tdata;
      if (expected_speeds.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", m_tdata));
      end else begin
        want = expected_speeds.pop_front();
        for (int c = 0; c < CHANNELS; c++) begin
          if (got[c] !== want[c])
            report_mismatch($sformatf("speed_%0d got %0d expected %0d", c, got[c], want[c]));
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either stream
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] en;
    logic [CHANNELS-1:0][TPR_W-1:0] ppr;
    logic kind;
    logic [CH_W-1:0] ch;
    logic [TIME_W-1:0] now_ms;
    int unsigned roll;

    // all channels off after reset: everything reads zero
    drill.push_back(known(edge_row(2'd0, 32'd1000), '0));
    drill.push_back(known(refresh_row(32'hFFFF_FFFF), '0));
    drill.push_back(known(edge_row(2'd3, 32'd0), '0));
    drill.push_back(regs_row(8'h0F, {8'd1, 8'd1, 8'd1, 8'd1}));
    // zero elapsed keeps the speed, one ms gives the top reading
    drill.push_back(known(edge_row(2'd0, 32'd0), '0));
    drill.push_back(known(edge_row(2'd0, 32'd1), 64'd60000));
    // huge interval, then one ms across the wrap
    drill.push_back(edge_row(2'd1, 32'hFFFF_FFFF));
    drill.push_back(edge_row(2'd1, 32'd0));
    drill.push_back(regs_row(8'h0F, {8'd1, 8'd255, 8'd1, 8'd1}));
    drill.push_back(edge_row(2'd2, 32'd100));
    drill.push_back(edge_row(2'd2, 32'd100));
    drill.push_back(refresh_row(32'd101));
    drill.push_back(refresh_row(32'd0));
    // zero pulses per revolution behaves as one
    drill.push_back(regs_row(8'h0F, {8'd0, 8'd255, 8'd1, 8'd1}));
    drill.push_back(edge_row(2'd3, 32'd200));
    drill.push_back(edge_row(2'd3, 32'd201));
    // disabled channel ignores edges and reads zero
    drill.push_back(regs_row(8'h05, {8'd0, 8'd255, 8'd1, 8'd1}));
    drill.push_back(edge_row(2'd1, 32'd500));
    // refresh whose horizon wrapped, elapsed zero keeps the speed
    drill.push_back(edge_row(2'd0, 32'h8000_0001));
    drill.push_back(refresh_row(32'h8000_0001));
    // re-enabled channels are refreshed and read out again
    drill.push_back(regs_row(8'h0F, {8'd255, 8'd255, 8'd255, 8'd255}));
    drill.push_back(refresh_row(32'h8000_0010));
    drill.push_back(edge_row(2'd3, 32'h8000_0000));
    drill.push_back(edge_row(2'd3, 32'h8000_00EB));
    drill.push_back(edge_row(2'd3, 32'h8000_00EC));
    drill.push_back(refresh_row(32'hFFFF_FFFF));
    // enable bits above the channel count are ignored
    drill.push_back(regs_row(8'hFA, {8'd7, 8'd3, 8'd2, 8'd1}));
    drill.push_back(refresh_row(32'd5));
    drill.push_back(edge_row(2'd1, 32'd9));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (drill[i]) begin
      if (drill[i].set_regs) begin
        settle();
        apply_regs(drill[i].enable_byte, drill[i].ppr);
      end else begin
        send_item(drill[i].kind, drill[i].ch, drill[i].now_ms,
                  drill[i].typed, drill[i].typed_speeds);
      end
    end

    // random phases, each starting from an idle block with new registers
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          en = 8'h0F;
          ppr = {8'd1, 8'd1, 8'd1, 8'd1};
        end
        1: begin
          en = 8'h0F;
          ppr = {8'd255, 8'd255, 8'd255, 8'd255};
        end
        2: begin
          en = 8'h0F;
          ppr = '0;
        end
        default: begin
          en = {4'($urandom), 4'($urandom_range(1, 15))};
          for (int c = 0; c < CHANNELS; c++)
            ppr[c] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 8));
        end
      endcase
      apply_regs(en, ppr);
      no_idle = (phase % 4 == 3);
      if (phase == 4) wall_ms = 32'hFFFF_FF00;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // mostly a steadily running clock, some long jumps and stray stamps
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          now_ms = $urandom;
        end else begin
          if (roll < 14) wall_ms += $urandom;
          else wall_ms += $urandom_range(0, 60);
          now_ms = wall_ms;
        end
        kind = ($urandom_range(0, 99) < 30) ? KIND_REFRESH : KIND_EDGE;
        if ($urandom_range(0, 99) < 85 && mirror_enable != '0) begin
          do ch = CH_W'($urandom_range(0, CHANNELS - 1)); while (!mirror_enable[ch]);
        end else begin
          ch = CH_W'($urandom_range(0, CHANNELS - 1));
        end
        send_item(kind, ch, now_ms, 1'b0, '0);
      end
    end

    settle();
    no_idle = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
